// ===== hdl/bbt_pkg.sv =====
// Shared types, widths and codes for the Bollinger band tracker.
package bbt_pkg;

   localparam int PRICE_W        = 24;
   localparam int LEN_W          = 9;
   localparam int MULT_W         = 16;
   localparam int UPPER_W        = 28;
   localparam int LOWER_W        = 28;
   localparam int PB_W           = 24;
   localparam int RATIO_W        = 24;
   localparam int OFS_W          = 28;
   localparam int DIV_W          = 46;
   localparam int CNT_W          = 6;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int RSP_W          = 128;
   localparam int WINDOW_MAX_DEF = 256;
   localparam logic [LEN_W-1:0]  WL_RESET = 9'd20;
   localparam logic [MULT_W-1:0] BM_RESET = 16'd8192;

   typedef enum logic {
      REG_WINDOW_LENGTH = 1'b0,
      REG_BAND_MULT     = 1'b1
   } reg_idx_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_SQUARES,
      OP_UPDATE,
      OP_NQ_LOAD,
      OP_S2_LOAD,
      OP_MUL_STEP,
      OP_SQRT_LOAD,
      OP_SQRT_STEP,
      OP_MEAN_LOAD,
      OP_SD_LOAD,
      OP_DIV_STEP,
      OP_OFFSET,
      OP_BANDS,
      OP_PB_LOAD,
      OP_RATIO_LOAD,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

// ===== hdl/bbt_ctrl.sv =====
// Sequencing state machine of the Bollinger band tracker.
module bbt_ctrl #(
   parameter int WINDOW_MAX = bbt_pkg::WINDOW_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bbt_pkg::sts_type sts,
   output bbt_pkg::cmd_type cmd
);
   import bbt_pkg::*;

   localparam int N_W   = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = PRICE_W + $clog2(WINDOW_MAX);
   localparam int SQ_W  = 2 * PRICE_W + $clog2(WINDOW_MAX);
   localparam int RT_W  = (SQ_W + N_W + 1) / 2;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_READ     = 14'b00000000000010,
      ST_UPDATE   = 14'b00000000000100,
      ST_MULNQ    = 14'b00000000001000,
      ST_MULS2    = 14'b00000000010000,
      ST_SQRT     = 14'b00000000100000,
      ST_DIVMEAN  = 14'b00000001000000,
      ST_DIVSD    = 14'b00000010000000,
      ST_OFFSET   = 14'b00000100000000,
      ST_BANDS    = 14'b00001000000000,
      ST_DIVPB    = 14'b00010000000000,
      ST_DIVRATIO = 14'b00100000000000,
      ST_DONE     = 14'b01000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] last;
   logic             iter;
   state_type        after;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      iter     = 1'b0;
      last     = CNT_W'(DIV_W);
      after    = ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.op   = OP_SQUARES;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = ST_MULNQ;
         end
         ST_MULNQ: begin
            iter   = 1'b1;
            last   = CNT_W'(N_W);
            after  = ST_MULS2;
            cmd.op = (cnt_ff == '0) ? OP_NQ_LOAD : OP_MUL_STEP;
         end
         ST_MULS2: begin
            iter   = 1'b1;
            last   = CNT_W'(SUM_W);
            after  = ST_SQRT;
            cmd.op = (cnt_ff == '0) ? OP_S2_LOAD : OP_MUL_STEP;
         end
         ST_SQRT: begin
            iter   = 1'b1;
            last   = CNT_W'(RT_W);
            after  = ST_DIVMEAN;
            cmd.op = (cnt_ff == '0) ? OP_SQRT_LOAD : OP_SQRT_STEP;
         end
         ST_DIVMEAN: begin
            iter   = 1'b1;
            after  = ST_DIVSD;
            cmd.op = (cnt_ff == '0) ? OP_MEAN_LOAD : OP_DIV_STEP;
         end
         ST_DIVSD: begin
            iter   = 1'b1;
            after  = ST_OFFSET;
            cmd.op = (cnt_ff == '0) ? OP_SD_LOAD : OP_DIV_STEP;
         end
         ST_OFFSET: begin
            cmd.op   = OP_OFFSET;
            state_in = ST_BANDS;
         end
         ST_BANDS: begin
            cmd.op   = OP_BANDS;
            state_in = ST_DIVPB;
         end
         ST_DIVPB: begin
            iter   = 1'b1;
            after  = ST_DIVRATIO;
            cmd.op = (cnt_ff == '0) ? OP_PB_LOAD : OP_DIV_STEP;
         end
         ST_DIVRATIO: begin
            iter   = 1'b1;
            after  = ST_DONE;
            cmd.op = (cnt_ff == '0) ? OP_RATIO_LOAD : OP_DIV_STEP;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (iter) begin
         if (cnt_ff == last) begin
            cnt_in   = '0;
            state_in = after;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hdl/bbt_dp.sv =====
// Datapath of the Bollinger band tracker: price ring, running sums, iterative units.
module bbt_dp #(
   parameter int WINDOW_MAX = bbt_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bbt_pkg::cmd_type              cmd,
   output bbt_pkg::sts_type              sts,
   input  logic                          restart,
   input  logic [bbt_pkg::LEN_W-1:0]     window_length,
   input  logic [bbt_pkg::MULT_W-1:0]    band_multiplier,
   input  logic [bbt_pkg::PRICE_W-1:0]   price,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bbt_pkg::RSP_W-1:0]     rsp_tdata
);
   import bbt_pkg::*;

   localparam int N_W    = $clog2(WINDOW_MAX + 1);
   localparam int SLOT_W = $clog2(WINDOW_MAX);
   localparam int SUM_W  = PRICE_W + SLOT_W;
   localparam int SQ_W   = 2 * PRICE_W + SLOT_W;
   localparam int D_W    = SQ_W + N_W;
   localparam int RT_W   = (D_W + 1) / 2;
   localparam int RAD_W  = 2 * RT_W;
   localparam int CMP_W  = (N_W > LEN_W) ? N_W : LEN_W;
   localparam int PSQ_W  = 2 * PRICE_W;

   logic [PRICE_W-1:0] ring [WINDOW_MAX];

   logic [PRICE_W-1:0] price_ff, old_ff;
   logic [PSQ_W-1:0]   psq_ff, osq_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [N_W-1:0]     fill_ff, fill_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [D_W-1:0]     acc_ff, cand_ff, nq_ff, diff;
   logic [SUM_W-1:0]   plier_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [RT_W+1:0]    rem_ff, rem_sh, trial;
   logic [RT_W-1:0]    root_ff;
   logic [DIV_W-1:0]   dq_ff, dvs_ff, pbq_ff;
   logic [DIV_W-1:0]   dr_ff;
   logic [DIV_W:0]     dr_sh;
   logic [PRICE_W-1:0] mean_ff;
   logic [OFS_W-1:0]   offset_ff;
   logic [OFS_W+1:0]   upper_ff;
   logic signed [OFS_W+1:0] lower_ff, lower_c;
   logic [OFS_W:0]     width_ff;
   logic               neg_ff;
   logic [OFS_W+1:0]   mag_ff;
   logic signed [OFS_W+2:0] num_c;
   logic [MULT_W+PRICE_W-1:0] ofs_prod;
   logic [N_W-1:0]     len;
   logic [CMP_W-1:0]   wl_x;
   logic               full;

   logic               rv_ff;
   logic [UPPER_W-1:0] up_ff;
   logic [LOWER_W-1:0] lo_ff;
   logic [PB_W-1:0]    pb_ff;
   logic [RATIO_W-1:0] ra_ff;
   logic [PRICE_W-1:0] mid_ff;
   logic [UPPER_W-1:0] up_sat;
   logic [LOWER_W-1:0] lo_sat;
   logic [PB_W-1:0]    pb_sat;
   logic [RATIO_W-1:0] ra_sat;

   // Window length zero acts as one, above the ring depth as the depth.
   always_comb begin
      wl_x = CMP_W'(window_length);
      if (wl_x == '0) begin
         len = N_W'(1);
      end else if (wl_x > CMP_W'(WINDOW_MAX)) begin
         len = N_W'(WINDOW_MAX);
      end else begin
         len = N_W'(wl_x);
      end
   end

   assign full    = (fill_ff == len);
   assign sum_in  = sum_ff - (full ? SUM_W'(old_ff) : '0) + SUM_W'(price_ff);
   assign sq_in   = sq_ff - (full ? SQ_W'(osq_ff) : '0) + SQ_W'(psq_ff);
   assign fill_in = full ? fill_ff : fill_ff + 1'b1;
   assign slot_in = (N_W'(slot_ff) + 1'b1 == len) ? '0 : slot_ff + 1'b1;

   assign diff   = (nq_ff > acc_ff) ? nq_ff - acc_ff : '0;
   assign rem_sh = {rem_ff[RT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign dr_sh  = {dr_ff, dq_ff[DIV_W-1]};

   assign ofs_prod = band_multiplier * dq_ff[PRICE_W-1:0];
   assign lower_c  = $signed({6'b0, mean_ff}) - $signed({2'b0, offset_ff});
   assign num_c    = $signed({7'b0, price_ff}) - $signed({lower_c[OFS_W+1], lower_c});

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         price_ff <= price;
         old_ff   <= ring[slot_ff];
      end
      if (cmd.op == OP_UPDATE) begin
         ring[slot_ff] <= price_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         sum_ff  <= '0;
         sq_ff   <= '0;
         fill_ff <= '0;
         slot_ff <= '0;
      end else if (cmd.op == OP_UPDATE) begin
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         fill_ff <= fill_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SQUARES: begin
            psq_ff <= price_ff * price_ff;
            osq_ff <= old_ff * old_ff;
         end
         OP_NQ_LOAD: begin
            acc_ff   <= '0;
            cand_ff  <= D_W'(sq_ff);
            plier_ff <= SUM_W'(fill_ff);
         end
         OP_S2_LOAD: begin
            nq_ff    <= acc_ff;
            acc_ff   <= '0;
            cand_ff  <= D_W'(sum_ff);
            plier_ff <= sum_ff;
         end
         OP_MUL_STEP: begin
            if (plier_ff[0]) begin
               acc_ff <= acc_ff + cand_ff;
            end
            cand_ff  <= cand_ff << 1;
            plier_ff <= plier_ff >> 1;
         end
         OP_SQRT_LOAD: begin
            rad_ff  <= RAD_W'(diff);
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            rad_ff <= rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[RT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[RT_W-2:0], 1'b0};
            end
         end
         OP_MEAN_LOAD: begin
            dq_ff  <= DIV_W'(sum_ff);
            dr_ff  <= '0;
            dvs_ff <= DIV_W'(fill_ff);
         end
         OP_SD_LOAD: begin
            mean_ff <= dq_ff[PRICE_W-1:0];
            dq_ff   <= DIV_W'(root_ff);
            dr_ff   <= '0;
            dvs_ff  <= DIV_W'(fill_ff);
         end
         OP_DIV_STEP: begin
            if (dr_sh >= {1'b0, dvs_ff}) begin
               dr_ff <= DIV_W'(dr_sh - {1'b0, dvs_ff});
               dq_ff <= {dq_ff[DIV_W-2:0], 1'b1};
            end else begin
               dr_ff <= dr_sh[DIV_W-1:0];
               dq_ff <= {dq_ff[DIV_W-2:0], 1'b0};
            end
         end
         OP_OFFSET: begin
            // The deviation never exceeds the largest price, so 24 bits hold it.
            offset_ff <= ofs_prod[MULT_W+PRICE_W-1:12];
         end
         OP_BANDS: begin
            upper_ff <= {6'b0, mean_ff} + {2'b0, offset_ff};
            lower_ff <= lower_c;
            width_ff <= {offset_ff, 1'b0};
            neg_ff   <= num_c[OFS_W+2];
            mag_ff   <= num_c[OFS_W+2] ? (OFS_W+2)'(0) - num_c[OFS_W+1:0]
                                       : num_c[OFS_W+1:0];
         end
         OP_PB_LOAD: begin
            dq_ff  <= {mag_ff, 16'b0};
            dr_ff  <= '0;
            dvs_ff <= DIV_W'(width_ff);
         end
         OP_RATIO_LOAD: begin
            pbq_ff <= dq_ff;
            dq_ff  <= DIV_W'({width_ff, 16'b0});
            dr_ff  <= '0;
            dvs_ff <= DIV_W'(mean_ff);
         end
         default: begin
         end
      endcase
   end

   // Saturation of the finished figures into the result fields.
   always_comb begin
      up_sat = (upper_ff > (OFS_W+2)'(2**UPPER_W - 1)) ? '1 : upper_ff[UPPER_W-1:0];
      lo_sat = (lower_ff < -$signed((OFS_W+2)'(2**(LOWER_W-1))))
               ? {1'b1, {(LOWER_W-1){1'b0}}} : lower_ff[LOWER_W-1:0];
      if (width_ff == '0) begin
         pb_sat = '0;
      end else if (neg_ff) begin
         pb_sat = (pbq_ff > DIV_W'(2**(PB_W-1))) ? {1'b1, {(PB_W-1){1'b0}}}
                                                 : PB_W'(0) - pbq_ff[PB_W-1:0];
      end else begin
         pb_sat = (pbq_ff > DIV_W'(2**(PB_W-1) - 1)) ? {1'b0, {(PB_W-1){1'b1}}}
                                                     : pbq_ff[PB_W-1:0];
      end
      if (mean_ff == '0) begin
         ra_sat = '0;
      end else begin
         ra_sat = (dq_ff > DIV_W'(2**RATIO_W - 1)) ? '1 : dq_ff[RATIO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_FINISH) begin
         mid_ff <= mean_ff;
         up_ff  <= up_sat;
         lo_ff  <= lo_sat;
         pb_ff  <= pb_sat;
         ra_ff  <= ra_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.op == OP_FINISH) begin
         rv_ff <= 1'b1;
      end else if (rsp_tready) begin
         rv_ff <= 1'b0;
      end
   end

   assign sts.out_busy = rv_ff && !rsp_tready;
   assign rsp_tvalid   = rv_ff;
   assign rsp_tdata    = {ra_ff, pb_ff, lo_ff, up_ff, mid_ff};

endmodule

// ===== hdl/bollinger_band_tracker.sv =====
// The four radix-2 divides dominate the time from the accepting edge to rsp_tvalid; a new
// request is taken only in the idle state, after the previous one has left its last state;
// the next request is taken while a result waits, and a result stalled by rsp_tready holds the
// following one in its last state. Reset clears the window, the sums and the result valid;
// registers return to window_length 20 and band_multiplier 8192. Any write restarts the window.
module bollinger_band_tracker #(
   parameter int WINDOW_MAX = bbt_pkg::WINDOW_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request: tdata[23:0] price.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,
   // Result: tdata[23:0] middle_band, [51:24] upper_band, [79:52] lower_band,
   // [103:80] band_pos, [127:104] band_ratio.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bbt_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bbt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bbt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bbt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bbt_pkg::*;

   logic [LEN_W-1:0]  wl_ff;
   logic [MULT_W-1:0] bm_ff;
   logic              wr_en;
   reg_idx_type       idx;
   cmd_type           cmd;
   sts_type           sts;

   // The register index is the word address; every write lands on one register.
   assign idx        = reg_idx_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WL_RESET;
         bm_ff <= BM_RESET;
      end else if (wr_en) begin
         case (idx)
            REG_WINDOW_LENGTH: wl_ff <= csr_pwdata[LEN_W-1:0];
            REG_BAND_MULT:     bm_ff <= csr_pwdata[MULT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_WINDOW_LENGTH: csr_prdata = CSR_DATA_W'(wl_ff);
         REG_BAND_MULT:     csr_prdata = CSR_DATA_W'(bm_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // The controller steps the datapath through update, multiply, root, divides, offset and bands.
   bbt_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbt_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .restart         (wr_en),
      .window_length   (wl_ff),
      .band_multiplier (bm_ff),
      .price           (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

// ===== hdl/bbt_checker.sv =====
// Port-level checks for the Bollinger band tracker, bound to the top level.
module bbt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [bbt_pkg::RSP_W-1:0] rsp_tdata
);
   import bbt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   a_upper_above_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[51:24] >= {4'b0, rsp_tdata[23:0]})
      else $error("upper band below middle band");

endmodule

bind bollinger_band_tracker bbt_checker u_bbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
